### rtl/lzwc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lzwc_pkg
// shared constants and controller/datapath handshake structs for the
// 12-bit lzw compressor
// ----------------------------------------------------------------------------
package lzwc_pkg;

  localparam int BYTE_W        = 8;
  localparam int CODE_W        = 12;
  localparam int KEY_W         = CODE_W + BYTE_W;
  localparam int NFREE_W       = 13;
  localparam int FIRST_CODE    = 256;
  localparam int DICT_SIZE_DEF = 4096;
  localparam int NIB_W         = 4;

  // output queue
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = 3;
  localparam int FIFO_CW    = 4;
  localparam int FIFO_SLACK = 4;   // worst-case bytes caused by one request

  // commands from controller to datapath
  typedef struct packed {
    logic idle;        // may take a new request
    logic take;        // latch incoming byte, compute home slot
    logic first;       // first byte of stream becomes prefix
    logic hash_rd;     // read hash slot
    logic dict_rd;     // latch slot code, read dictionary entry
    logic probe_next;  // advance to next slot
    logic hit;         // prefix takes matched code
    logic miss;        // queue prefix code, insert pair, restart prefix
    logic flush_load;  // queue final prefix code
    logic emit_a;      // first byte of a code
    logic emit_b;      // second byte of a code
    logic emit_pad;    // padding byte
    logic clear;       // end of stream
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic fire;
    logic last;
    logic prefix_valid;
    logic owned;
    logic match;
    logic pending;
    logic flush;
  } sts_t;

endpackage
`default_nettype wire

### rtl/lzwc_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lzwc channel interfaces
// valid/ready channels for uncompressed bytes and packed code bytes
// ----------------------------------------------------------------------------
interface lzwc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;
  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface lzwc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_end;
  logic       stream_end;
  modport source (output valid, output out_byte, output run_end, output stream_end,
                  input ready);
  modport sink   (input valid, input out_byte, input run_end, input stream_end,
                  output ready);
endinterface
`default_nettype wire

### rtl/lzwc_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lzwc_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module lzwc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### rtl/lzwc_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lzwc_ctrl
// sequencer: lookup probe loop, code byte emission and stream flush
// ----------------------------------------------------------------------------
module lzwc_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire lzwc_pkg::sts_t sts,
  output      lzwc_pkg::cmd_t cmd
);
  import lzwc_pkg::*;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_GO    = 4'd1;
  localparam logic [3:0] ST_HRD   = 4'd2;
  localparam logic [3:0] ST_DRD   = 4'd3;
  localparam logic [3:0] ST_CMP   = 4'd4;
  localparam logic [3:0] ST_FLUSH = 4'd5;
  localparam logic [3:0] ST_CODEA = 4'd6;
  localparam logic [3:0] ST_CODEB = 4'd7;
  localparam logic [3:0] ST_DONE  = 4'd8;
  localparam logic [3:0] ST_PAD   = 4'd9;

  logic [3:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        cmd.idle = 1'b1;
        if (sts.fire) begin
          cmd.take   = 1'b1;
          state_next = ST_GO;
        end
      end
      ST_GO: begin
        if (!sts.prefix_valid) begin
          cmd.first  = 1'b1;
          state_next = sts.last ? ST_FLUSH : ST_IDLE;
        end else begin
          state_next = ST_HRD;
        end
      end
      ST_HRD: begin
        cmd.hash_rd = 1'b1;
        state_next  = ST_DRD;
      end
      ST_DRD: begin
        cmd.dict_rd = 1'b1;
        state_next  = ST_CMP;
      end
      ST_CMP: begin
        priority if (sts.match) begin
          cmd.hit    = 1'b1;
          state_next = sts.last ? ST_FLUSH : ST_IDLE;
        end else if (sts.owned) begin
          cmd.probe_next = 1'b1;
          state_next     = ST_HRD;
        end else begin
          cmd.miss   = 1'b1;
          state_next = ST_CODEA;
        end
      end
      ST_FLUSH: begin
        cmd.flush_load = 1'b1;
        state_next     = ST_CODEA;
      end
      ST_CODEA: begin
        cmd.emit_a = 1'b1;
        state_next = sts.pending ? ST_CODEB : ST_DONE;
      end
      ST_CODEB: begin
        cmd.emit_b = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        priority if (sts.flush) begin
          if (sts.pending) begin
            state_next = ST_PAD;
          end else begin
            cmd.clear  = 1'b1;
            state_next = ST_IDLE;
          end
        end else if (sts.last) begin
          state_next = ST_FLUSH;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_PAD: begin
        cmd.emit_pad = 1'b1;
        cmd.clear    = 1'b1;
        state_next   = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

### rtl/lzwc_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lzwc_dp
// datapath: prefix state, hashed dictionary rams, code packer, output queue
// ----------------------------------------------------------------------------
module lzwc_dp #(
  parameter int DICT_SIZE = lzwc_pkg::DICT_SIZE_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  lzwc_in_if.sink             byte_chan,
  lzwc_out_if.source          code_chan,
  input  wire lzwc_pkg::cmd_t cmd,
  output      lzwc_pkg::sts_t sts
);
  import lzwc_pkg::*;

  localparam int AW = $clog2(DICT_SIZE);
  localparam int OUT_W = BYTE_W + 2;

  // stream state
  logic [NFREE_W-1:0] next_free;
  logic [CODE_W-1:0]  prefix;
  logic               prefix_valid;
  logic [NIB_W-1:0]   held;
  logic               pending;
  logic               flush;

  // per request
  logic [BYTE_W-1:0]  cur_byte;
  logic               cur_last;
  logic [AW-1:0]      slot;
  logic [CODE_W-1:0]  probe_code;
  logic [CODE_W-1:0]  emit_code;

  logic [CODE_W-1:0]      hash_rdata;
  logic [KEY_W+AW-1:0]    dict_rdata;
  logic [KEY_W-1:0]       key;
  logic                   room_in_dict;
  logic                   ins;
  logic                   owned;

  assign key          = {prefix, cur_byte};
  assign room_in_dict = next_free < NFREE_W'(DICT_SIZE);
  assign ins          = cmd.miss && room_in_dict;

  // a slot counts only if its code was issued in this stream and points back
  assign owned = (probe_code >= CODE_W'(FIRST_CODE))
              && ({1'b0, probe_code} < next_free)
              && (dict_rdata[AW-1:0] == slot);

  lzwc_ram #(.WIDTH(CODE_W), .DEPTH(DICT_SIZE)) u_hash (
    .clk   (clk),
    .we    (ins),
    .waddr (slot),
    .wdata (next_free[CODE_W-1:0]),
    .re    (cmd.hash_rd),
    .raddr (slot),
    .rdata (hash_rdata)
  );

  lzwc_ram #(.WIDTH(KEY_W + AW), .DEPTH(DICT_SIZE)) u_dict (
    .clk   (clk),
    .we    (ins),
    .waddr (next_free[AW-1:0]),
    .wdata ({key, slot}),
    .re    (cmd.dict_rd),
    .raddr (hash_rdata[AW-1:0]),
    .rdata (dict_rdata)
  );

  // output queue
  logic [OUT_W-1:0]   fifo [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr, rd_ptr;
  logic [FIFO_CW-1:0] count;
  logic               push, pop;
  logic [OUT_W-1:0]   push_data;

  always_comb begin
    push      = 1'b0;
    push_data = '0;
    priority if (cmd.emit_a) begin
      push = 1'b1;
      if (pending) begin
        push_data = {held, emit_code[CODE_W-1:8], 1'b0, 1'b0};
      end else begin
        push_data = {emit_code[CODE_W-1:4], !cur_last, 1'b0};
      end
    end else if (cmd.emit_b) begin
      push      = 1'b1;
      push_data = {emit_code[7:0], flush || !cur_last, flush};
    end else if (cmd.emit_pad) begin
      push      = 1'b1;
      push_data = {held, 4'h0, 1'b1, 1'b1};
    end else begin
      push = 1'b0;
    end
  end

  assign pop = code_chan.valid && code_chan.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + FIFO_CW'(push) - FIFO_CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= push_data;
    end
  end

  assign code_chan.valid      = count != '0;
  assign code_chan.out_byte   = fifo[rd_ptr][OUT_W-1:2];
  assign code_chan.run_end    = fifo[rd_ptr][1];
  assign code_chan.stream_end = fifo[rd_ptr][0];

  assign byte_chan.ready = cmd.idle && (count <= FIFO_CW'(FIFO_SLACK));

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      next_free    <= NFREE_W'(FIRST_CODE);
      prefix       <= '0;
      prefix_valid <= 1'b0;
      held         <= '0;
      pending      <= 1'b0;
      flush        <= 1'b0;
    end else begin
      if (cmd.first) begin
        prefix       <= CODE_W'(cur_byte);
        prefix_valid <= 1'b1;
      end
      if (cmd.hit) begin
        prefix <= probe_code;
      end
      if (cmd.miss) begin
        prefix <= CODE_W'(cur_byte);
      end
      if (ins) begin
        next_free <= next_free + 1'b1;
      end
      if (cmd.flush_load) begin
        flush <= 1'b1;
      end
      if (cmd.emit_a) begin
        if (!pending) begin
          held <= emit_code[3:0];
        end
        pending <= !pending;
      end
      if (cmd.emit_b) begin
        pending <= 1'b0;
      end
      if (cmd.clear) begin
        next_free    <= NFREE_W'(FIRST_CODE);
        prefix       <= '0;
        prefix_valid <= 1'b0;
        held         <= '0;
        pending      <= 1'b0;
        flush        <= 1'b0;
      end
    end
  end

  // home slot is set once the prefix is known, before the first hash read
  logic home_load;
  logic [AW-1:0] home;
  assign home = prefix[AW-1:0] ^ {cur_byte, {(AW-BYTE_W){1'b0}}};

  always_ff @(posedge clk) begin
    if (rst) begin
      home_load <= 1'b0;
    end else begin
      home_load <= cmd.take;
    end
  end

  // request payload
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      cur_byte <= byte_chan.in_byte;
      cur_last <= byte_chan.in_last;
    end
    if (home_load) begin
      slot <= home;
    end
    if (cmd.probe_next) begin
      slot <= slot + 1'b1;
    end
    if (cmd.dict_rd) begin
      probe_code <= hash_rdata;
    end
    if (cmd.miss) begin
      emit_code <= prefix;
    end
    if (cmd.flush_load) begin
      emit_code <= prefix;
    end
  end

  assign sts.fire         = byte_chan.valid && byte_chan.ready;
  assign sts.last         = cur_last;
  assign sts.prefix_valid = prefix_valid;
  assign sts.owned        = owned;
  assign sts.match        = owned && (dict_rdata[KEY_W+AW-1:AW] == key);
  assign sts.pending      = pending;
  assign sts.flush        = flush;

endmodule
`default_nettype wire

### rtl/lzw_compressor_12bit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lzw_compressor_12bit
// lzw compressor with fixed 12-bit codes, two codes packed into three bytes
// ----------------------------------------------------------------------------
//
//  channel    | role   | payload                          | request
//  -----------+--------+----------------------------------+---------------------
//  byte_chan  | sink   | in_byte[7:0], in_last            | one uncompressed byte
//  code_chan  | source | out_byte[7:0], run_end, stream_end| one packed code byte
//
//  a request for the first byte of a stream only loads the prefix; a lookup
//  reads the hash ram, then the dictionary ram and compares, once per hash
//  probe; a miss adds code output and a flush adds the final code and any
//  padding byte.
//  reset is synchronous; the dictionary needs no clearing pass, a slot only
//  counts when its code was issued in the current stream.
//  an 8-byte output queue decouples the two sides; byte_chan is ready only
//  while idle with room for the four bytes a request can cause.
//
module lzw_compressor_12bit #(
  parameter int DICT_SIZE = lzwc_pkg::DICT_SIZE_DEF
) (
  input wire logic   clk,
  input wire logic   rst,
  lzwc_in_if.sink    byte_chan,
  lzwc_out_if.source code_chan
);
  import lzwc_pkg::*;

  cmd_t cmd;   // controller commands
  sts_t sts;   // datapath status

  // sequencer for probe loop and code output
  lzwc_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  // dictionary, prefix state and output queue
  lzwc_dp #(.DICT_SIZE(DICT_SIZE)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .byte_chan (byte_chan),
    .code_chan (code_chan),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
`default_nettype wire

### rtl/lzwc_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lzwc_checker
// port-level checks for the lzw compressor, bound to the top level
// ----------------------------------------------------------------------------
module lzwc_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [7:0] out_byte,
  input wire logic run_end,
  input wire logic stream_end
);

  // stalled output holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte)
      && $stable(run_end) && $stable(stream_end))
    else $error("stalled output changed");

  // end of stream closes the request too
  a_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && stream_end |-> run_end)
    else $error("stream_end without run_end");

  // a taken request keeps the block busy next cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken back to back");

  // queue is empty after reset
  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind lzw_compressor_12bit lzwc_checker u_lzwc_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (byte_chan.valid),
  .in_ready   (byte_chan.ready),
  .out_valid  (code_chan.valid),
  .out_ready  (code_chan.ready),
  .out_byte   (code_chan.out_byte),
  .run_end    (code_chan.run_end),
  .stream_end (code_chan.stream_end)
);
`default_nettype wire

### dv/lzw_compressor_12bit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lzw_compressor_12bit_tb
// drives byte streams into the compressor, predicts the packed code bytes
// with a behavioral lzw model and compares every output byte in order
// ----------------------------------------------------------------------------
module lzw_compressor_12bit_tb;
  import lzwc_pkg::*;

  localparam int DSIZE     = DICT_SIZE_DEF;
  localparam int MAX_CYCLE = 2000000;

  typedef struct packed {
    logic [7:0] data;
    logic       run_end;
    logic       stream_end;
  } code_byte_t;

  // directed table row; chk marks rows whose bytes are typed in
  typedef struct {
    logic [7:0] data;
    logic       last;
    bit         chk;
    int         n;
    code_byte_t exp [4];
  } stim_row_t;

  logic clk;
  logic rst;

  lzwc_in_if  byte_chan ();
  lzwc_out_if code_chan ();

  lzw_compressor_12bit u_dut (
    .clk       (clk),
    .rst       (rst),
    .byte_chan (byte_chan.sink),
    .code_chan (code_chan.source)
  );

  // predictor state
  logic [19:0]  dict_key [DSIZE];
  logic [12:0]  free_code;
  logic [11:0]  prefix;
  logic         have_prefix;
  logic [3:0]   nib;
  logic         nib_held;
  code_byte_t   pending_bytes [$];
  code_byte_t   typed_bytes [$];

  int  errors;
  int  cycles;
  bit  stall_free;
  bit  use_typed;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // pack one 12-bit code into the byte queue, holding the odd nibble
  task automatic pack_code(input logic [11:0] code, inout code_byte_t bq [$]);
    if (nib_held) begin
      bq.push_back('{ {nib, code[11:8]}, 1'b0, 1'b0 });
      bq.push_back('{ code[7:0], 1'b0, 1'b0 });
      nib_held = 1'b0;
    end else begin
      bq.push_back('{ code[11:4], 1'b0, 1'b0 });
      nib      = code[3:0];
      nib_held = 1'b1;
    end
  endtask

  task automatic lzw_predict(input logic [7:0] b, input logic last);
    code_byte_t bq [$];
    logic [19:0] key;
    int hit;
    hit = -1;
    if (!have_prefix) begin
      prefix      = {4'h0, b};
      have_prefix = 1'b1;
    end else begin
      key = {prefix, b};
      for (int c = FIRST_CODE; c < free_code && c < DSIZE; c++)
        if (dict_key[c] == key) begin
          hit = c;
          break;
        end
      if (hit >= 0) prefix = hit[11:0];
      else begin
        pack_code(prefix, bq);
        if (free_code < DSIZE) begin
          dict_key[free_code] = key;
          free_code++;
        end
        prefix = {4'h0, b};
      end
    end
    if (last) begin
      pack_code(prefix, bq);
      if (nib_held) bq.push_back('{ {nib, 4'h0}, 1'b0, 1'b0 });
      bq[$].stream_end = 1'b1;
      free_code   = FIRST_CODE;
      prefix      = '0;
      have_prefix = 1'b0;
      nib         = '0;
      nib_held    = 1'b0;
    end
    if (bq.size() > 0) bq[$].run_end = 1'b1;
    foreach (bq[i]) pending_bytes.push_back(bq[i]);
  endtask

  // one request on the byte channel
  task automatic send_byte(input logic [7:0] b, input logic last);
    while (!stall_free && $urandom_range(99) < 17) @(posedge clk);
    byte_chan.valid   <= 1'b1;
    byte_chan.in_byte <= b;
    byte_chan.in_last <= last;
    @(posedge clk);
    while (!byte_chan.ready) @(posedge clk);
    lzw_predict(b, last);
    byte_chan.valid <= 1'b0;
    @(posedge clk);
  endtask

  // output side: random back-pressure and in-order compare
  always @(posedge clk) begin
    code_byte_t got, want;
    if (rst) begin
      code_chan.ready <= 1'b0;
    end else begin
      if (code_chan.valid && code_chan.ready) begin
        got = '{ code_chan.out_byte, code_chan.run_end, code_chan.stream_end };
        if (pending_bytes.size() == 0) begin
          $display("%0t: unexpected byte %h", $time, got);
          errors++;
        end else begin
          want = pending_bytes.pop_front();
          if (use_typed && typed_bytes.size() > 0) want = typed_bytes.pop_front();
          if (got.data != want.data)
            $display("%0t: out_byte exp %h got %h", $time, want.data, got.data);
          if (got.run_end != want.run_end)
            $display("%0t: run_end exp %b got %b", $time, want.run_end, got.run_end);
          if (got.stream_end != want.stream_end)
            $display("%0t: stream_end exp %b got %b", $time, want.stream_end,
                     got.stream_end);
          if (got != want) errors++;
        end
      end
      code_chan.ready <= stall_free || ($urandom_range(99) >= 17);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > MAX_CYCLE) begin
      $display("lzw_compressor_12bit_tb NOT OK");
      $finish;
    end
  end

  initial begin
    stim_row_t rows [$];
    stim_row_t r;
    logic [7:0] alpha;
    int len;
    errors      = 0;
    cycles      = 0;
    stall_free  = 1'b0;
    use_typed   = 1'b0;
    free_code   = FIRST_CODE;
    prefix      = '0;
    have_prefix = 1'b0;
    nib         = '0;
    nib_held    = 1'b0;
    rst               = 1'b1;
    byte_chan.valid   = 1'b0;
    byte_chan.in_byte = '0;
    byte_chan.in_last = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // single-byte stream right after reset: code 0x0ff then padding
    r = '{data: 8'hff, last: 1'b1, chk: 1, n: 2, exp: '{default: '0}};
    r.exp[0] = '{8'h0f, 1'b0, 1'b0};
    r.exp[1] = '{8'hf0, 1'b1, 1'b1};
    rows.push_back(r);
    // single zero byte
    r.data = 8'h00;
    r.exp[0] = '{8'h00, 1'b0, 1'b0};
    r.exp[1] = '{8'h00, 1'b1, 1'b1};
    rows.push_back(r);
    // first byte gives no result
    r = '{data: 8'h41, last: 1'b0, chk: 1, n: 0, exp: '{default: '0}};
    rows.push_back(r);
    // miss: code 0x041, nibble held
    r = '{data: 8'h42, last: 1'b0, chk: 1, n: 1, exp: '{default: '0}};
    r.exp[0] = '{8'h04, 1'b1, 1'b0};
    rows.push_back(r);
    // repeated pairs exercise hits; predictor only
    for (int i = 0; i < 16; i++) begin
      r = '{data: (i % 2) ? 8'h42 : 8'h41, last: 1'b0, chk: 0, n: 0,
            exp: '{default: '0}};
      if (i >= 8) r.data = (i % 2) ? 8'haa : 8'h55;
      rows.push_back(r);
    end
    // flush with nibble pending then even flush
    r = '{data: 8'h80, last: 1'b1, chk: 0, n: 0, exp: '{default: '0}};
    rows.push_back(r);
    r.data = 8'h7f; r.last = 1'b0; rows.push_back(r);
    r.data = 8'h01; r.last = 1'b1; rows.push_back(r);

    foreach (rows[i]) begin
      use_typed = rows[i].chk;
      for (int k = 0; k < rows[i].n; k++) typed_bytes.push_back(rows[i].exp[k]);
      send_byte(rows[i].data, rows[i].last);
      while (pending_bytes.size() > 0) @(posedge clk);
      if (typed_bytes.size() != 0) begin
        $display("%0t: typed bytes exp %0d more got 0", $time, typed_bytes.size());
        errors++;
        typed_bytes.delete();
      end
    end
    use_typed = 1'b0;

    // random streams: mostly small alphabets so that dictionary hits occur
    for (int s = 0; s < 25; s++) begin
      len   = (s == 10) ? 1 : $urandom_range(20, 2);
      alpha = (s % 3 == 0) ? 8'hff : 8'h03;
      stall_free = (s >= 20 && s < 24);
      for (int i = 0; i < len; i++)
        send_byte((8'($urandom()) & alpha) ^ ((s % 5 == 0) ? 8'h80 : 8'h00),
                  i == len - 1);
    end
    stall_free = 1'b0;

    // a random two-symbol stream of 40 bytes
    for (int i = 0; i < 40; i++)
      send_byte(8'($urandom()) & 8'h01, i == 39);

    while (pending_bytes.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) $display("lzw_compressor_12bit_tb OK");
    else $display("lzw_compressor_12bit_tb NOT OK");
    $finish;
  end
endmodule
